>>> rtl/lbvs_pkg.sv
// Shared types and constants for the linear blend skinning unit.
// Holds the controller command and status structs and the fixed arithmetic widths.
// No dependencies.
`default_nettype none
package lbvs_pkg;

  // Words per bone matrix (3 rows by 4 columns)
  localparam int MAT_WORDS = 12;
  // Squared length threshold of a rotated normal (0.0001^2 in units of 2^-32)
  localparam int NRM_MIN_SQ = 42;
  // Total weight threshold (0.0001 in Q0.16)
  localparam int WEIGHT_MIN = 6;
  // Width of the row accumulators and the weighted sums
  localparam int ACC_W = 50;
  // Width of the total weight
  localparam int WTOT_W = 18;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_RD,
    OP_MUL_N,
    OP_MUL_P,
    OP_ACC_P,
    OP_ADD_T,
    OP_ROW_END,
    OP_SQ_MUL,
    OP_SQ_ACC,
    OP_SQRT_GO,
    OP_DIV_NRM,
    OP_NRM_ST,
    OP_NRM_FALL,
    OP_WMUL_P,
    OP_WACC_P,
    OP_WMUL_N,
    OP_WACC_N,
    OP_WTOT,
    OP_DIV_FIN,
    OP_FIN_ST,
    OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] slot;
    logic [1:0] row;
    logic [2:0] idx;
    logic       vsel;   // 0: rotated normal, 1: blended normal sum
  } cmd_t;

  typedef struct packed {
    logic w_zero;
    logic bone_skip;
    logic sq_big;
    logic skinned;
    logic sqrt_busy;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/linear_blend_vertex_skinning_unit.sv
// Linear blend vertex skinning, up to four bone influences per vertex.
// Input transactions (in_valid/in_ready) either load one bone matrix word (cmd 0)
// or skin one vertex (cmd 1). Loads are taken and give no result.
// A vertex gives one result transaction on out_valid/out_ready.
// For each influence used, the shared 32x32 multiplier works through 3 matrix
// rows, then a square root and three divides renormalise the rotated normal,
// which falls back to the input normal when too short to renormalise. A skinned
// vertex then takes six final divides and a second normalisation, which gives a
// zero normal when the blended normal is zero. One vertex is in flight at a
// time; in_ready is high only between vertices and returns the cycle after the
// result is loaded. bone_count is written through cfg_we/cfg_wdata; the user
// must write it only while the unit is idle, which the block does not enforce.
// Reset clears bone_count and the control state; the matrix store is not
// cleared and must be loaded before a bone is used.
// A stalled receiver holds the result in the output register; the next vertex
// is still taken and worked on, and waits to publish until the register frees.
// Depends on lbvs_pkg, lbvs_ctrl and lbvs_dp.
`default_nettype none
module linear_blend_vertex_skinning_unit #(
  parameter int MAX_BONES      = 256,
  parameter int MAX_INFLUENCES = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               cmd,
  input  wire logic [7:0]         load_bone,
  input  wire logic [3:0]         load_element,
  input  wire logic signed [31:0] load_value,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] nrm_x,
  input  wire logic signed [31:0] nrm_y,
  input  wire logic signed [31:0] nrm_z,
  input  wire logic [31:0]        influence_bones,
  input  wire logic [63:0]        influence_weights,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_wdata,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [31:0]      out_nrm_x,
  output logic signed [31:0]      out_nrm_y,
  output logic signed [31:0]      out_nrm_z,
  output logic                    was_skinned
);

  localparam int NUM_SLOTS = (MAX_INFLUENCES < 4) ? MAX_INFLUENCES : 4;

  logic           in_fire;
  lbvs_pkg::cmd_t ctl_cmd;
  lbvs_pkg::sts_t dp_sts;

  assign in_fire = in_valid && in_ready;

  lbvs_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .vtx_fire (in_fire && cmd),
    .sts      (dp_sts),
    .in_ready (in_ready),
    .cmd      (ctl_cmd)
  );

  lbvs_dp #(.MAX_BONES(MAX_BONES)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .in_fire           (in_fire),
    .cmd_in            (cmd),
    .load_bone         (load_bone),
    .load_element      (load_element),
    .load_value        (load_value),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .pos_z             (pos_z),
    .nrm_x             (nrm_x),
    .nrm_y             (nrm_y),
    .nrm_z             (nrm_z),
    .influence_bones   (influence_bones),
    .influence_weights (influence_weights),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (ctl_cmd),
    .sts               (dp_sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pos_z         (out_pos_z),
    .out_nrm_x         (out_nrm_x),
    .out_nrm_y         (out_nrm_y),
    .out_nrm_z         (out_nrm_z),
    .was_skinned       (was_skinned)
  );

endmodule
`default_nettype wire

>>> rtl/lbvs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module lbvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then read with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/lbvs_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Quotient truncates toward zero and saturates to 32 bits. Uses lbvs_pkg.
`default_nettype none
module lbvs_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [lbvs_pkg::ACC_W-1:0] dividend,
  input  wire logic        [31:0]                divisor,
  output logic                                   busy,
  output logic signed      [31:0]                quot
);

  localparam int N  = lbvs_pkg::ACC_W;
  localparam int CW = $clog2(N + 1);

  logic          neg;
  logic [N-1:0]  mag;
  logic [31:0]   rem;
  logic [31:0]   dvs;
  logic [CW-1:0] cnt;
  logic [32:0]   shifted;
  logic          fits;
  logic          pos_over;
  logic          neg_over;

  assign shifted = {rem, mag[N-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // Shift one dividend bit in per cycle, quotient bits replace it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(N);
      neg  <= dividend[N-1];
      mag  <= dividend[N-1] ? N'(-dividend) : N'(dividend);
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= fits ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
      mag  <= {mag[N-2:0], fits};
      cnt  <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Saturate the signed quotient
  assign pos_over = |mag[N-1:31];
  assign neg_over = (|mag[N-1:32]) || (mag[31] && (|mag[30:0]));

  always_comb begin
    if (!neg) begin
      quot = pos_over ? 32'sh7fffffff : $signed(mag[31:0]);
    end else begin
      quot = neg_over ? 32'sh80000000 : $signed(32'(-mag[31:0]));
    end
  end

endmodule
`default_nettype wire

>>> rtl/lbvs_sqrt.sv
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Result rounds down. Uses no package.
`default_nettype none
module lbvs_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             busy,
  output logic [31:0]      root
);

  logic [63:0] x;
  logic [34:0] rem;
  logic [5:0]  cnt;
  logic [34:0] sh;
  logic [34:0] trial;
  logic        fits;

  assign sh    = {rem[32:0], x[63:62]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = sh >= trial;

  // Take two radicand bits per cycle, settle one root bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      x    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= fits ? sh - trial : sh;
      root <= {root[30:0], fits};
      x    <= {x[61:0], 2'b00};
      cnt  <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/lbvs_ctrl.sv
// Controller: sequences influences, matrix rows, normalisation and the final divide.
// Issues one command per cycle to the datapath. Uses lbvs_pkg.
`default_nettype none
module lbvs_ctrl #(
  parameter int NUM_SLOTS = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           vtx_fire,
  input  wire lbvs_pkg::sts_t sts,
  output logic                in_ready,
  output lbvs_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SLOT, S_RD, S_MN, S_MP, S_AP, S_T3, S_ROWEND,
    S_SQ, S_SQACC, S_SQCHK, S_SQRT_GO, S_SQRT_WAIT,
    S_NDIV_GO, S_NDIV_WAIT, S_NDIV_ST, S_NFALL,
    S_WMP, S_WAP, S_WMN, S_WAN, S_WTOT,
    S_FCHK, S_FDIV_GO, S_FDIV_WAIT, S_FDIV_ST, S_PUB
  } state_t;

  state_t     state;
  logic [2:0] slot;
  logic [1:0] row;
  logic [2:0] idx;
  logic       vsel;

  assign in_ready = (state == S_IDLE);

  // Decode the command for the current step
  always_comb begin
    cmd.slot = slot;
    cmd.row  = row;
    cmd.idx  = idx;
    cmd.vsel = vsel;
    case (state)
      S_RD:      cmd.op = lbvs_pkg::OP_RD;
      S_MN:      cmd.op = lbvs_pkg::OP_MUL_N;
      S_MP:      cmd.op = lbvs_pkg::OP_MUL_P;
      S_AP:      cmd.op = lbvs_pkg::OP_ACC_P;
      S_T3:      cmd.op = lbvs_pkg::OP_ADD_T;
      S_ROWEND:  cmd.op = lbvs_pkg::OP_ROW_END;
      S_SQ:      cmd.op = lbvs_pkg::OP_SQ_MUL;
      S_SQACC:   cmd.op = lbvs_pkg::OP_SQ_ACC;
      S_SQRT_GO: cmd.op = lbvs_pkg::OP_SQRT_GO;
      S_NDIV_GO: cmd.op = lbvs_pkg::OP_DIV_NRM;
      S_NDIV_ST: cmd.op = lbvs_pkg::OP_NRM_ST;
      S_NFALL:   cmd.op = lbvs_pkg::OP_NRM_FALL;
      S_WMP:     cmd.op = lbvs_pkg::OP_WMUL_P;
      S_WAP:     cmd.op = lbvs_pkg::OP_WACC_P;
      S_WMN:     cmd.op = lbvs_pkg::OP_WMUL_N;
      S_WAN:     cmd.op = lbvs_pkg::OP_WACC_N;
      S_WTOT:    cmd.op = lbvs_pkg::OP_WTOT;
      S_FDIV_GO: cmd.op = lbvs_pkg::OP_DIV_FIN;
      S_FDIV_ST: cmd.op = lbvs_pkg::OP_FIN_ST;
      S_PUB:     cmd.op = lbvs_pkg::OP_PUBLISH;
      default:   cmd.op = lbvs_pkg::OP_IDLE;
    endcase
  end

  // Advance state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
      row   <= '0;
      idx   <= '0;
      vsel  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (vtx_fire) begin
            slot  <= '0;
            vsel  <= 1'b0;
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (slot == 3'(NUM_SLOTS) || sts.w_zero) begin
            state <= S_FCHK;
          end else if (sts.bone_skip) begin
            slot <= slot + 3'd1;
          end else begin
            row   <= '0;
            idx   <= '0;
            state <= S_RD;
          end
        end
        S_RD:   state <= (idx == 3'd3) ? S_T3 : S_MN;
        S_MN:   state <= S_MP;
        S_MP:   state <= S_AP;
        S_AP: begin
          idx   <= idx + 3'd1;
          state <= S_RD;
        end
        S_T3:   state <= S_ROWEND;
        S_ROWEND: begin
          idx <= '0;
          if (row == 2'd2) begin
            state <= S_SQ;
          end else begin
            row   <= row + 2'd1;
            state <= S_RD;
          end
        end
        S_SQ:   state <= S_SQACC;
        S_SQACC: begin
          if (idx == 3'd2) begin
            state <= S_SQCHK;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_SQ;
          end
        end
        S_SQCHK:   state <= sts.sq_big ? S_SQRT_GO : S_NFALL;
        S_SQRT_GO: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (!sts.sqrt_busy) begin
            idx   <= '0;
            state <= S_NDIV_GO;
          end
        end
        S_NDIV_GO: state <= S_NDIV_WAIT;
        S_NDIV_WAIT: begin
          if (!sts.div_busy) begin
            state <= S_NDIV_ST;
          end
        end
        S_NDIV_ST: begin
          if (idx == 3'd2) begin
            row   <= '0;
            state <= vsel ? S_PUB : S_WMP;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_NDIV_GO;
          end
        end
        S_NFALL: begin
          row   <= '0;
          state <= vsel ? S_PUB : S_WMP;
        end
        S_WMP: state <= S_WAP;
        S_WAP: state <= S_WMN;
        S_WMN: state <= S_WAN;
        S_WAN: begin
          if (row == 2'd2) begin
            state <= S_WTOT;
          end else begin
            row   <= row + 2'd1;
            state <= S_WMP;
          end
        end
        S_WTOT: begin
          slot  <= slot + 3'd1;
          state <= S_SLOT;
        end
        S_FCHK: begin
          idx   <= '0;
          state <= sts.skinned ? S_FDIV_GO : S_PUB;
        end
        S_FDIV_GO: state <= S_FDIV_WAIT;
        S_FDIV_WAIT: begin
          if (!sts.div_busy) begin
            state <= S_FDIV_ST;
          end
        end
        S_FDIV_ST: begin
          if (idx == 3'd5) begin
            idx   <= '0;
            vsel  <= 1'b1;
            state <= S_SQ;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_FDIV_GO;
          end
        end
        S_PUB: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/lbvs_dp.sv
// Datapath: bone matrix store, shared multiplier, accumulators, output register.
// Depends on lbvs_pkg, lbvs_ram, lbvs_div and lbvs_sqrt.
`default_nettype none
module lbvs_dp #(
  parameter int MAX_BONES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic               cmd_in,
  input  wire logic [7:0]         load_bone,
  input  wire logic [3:0]         load_element,
  input  wire logic signed [31:0] load_value,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] nrm_x,
  input  wire logic signed [31:0] nrm_y,
  input  wire logic signed [31:0] nrm_z,
  input  wire logic [31:0]        influence_bones,
  input  wire logic [63:0]        influence_weights,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_wdata,
  input  wire lbvs_pkg::cmd_t     cmd,
  output lbvs_pkg::sts_t          sts,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [31:0]      out_nrm_x,
  output logic signed [31:0]      out_nrm_y,
  output logic signed [31:0]      out_nrm_z,
  output logic                    was_skinned
);

  localparam int DEPTH = MAX_BONES * lbvs_pkg::MAT_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int AC    = lbvs_pkg::ACC_W;
  localparam int WW    = lbvs_pkg::WTOT_W;

  function automatic logic signed [31:0] sat32(input logic signed [AC-1:0] x);
    if ((&x[AC-1:31]) || !(|x[AC-1:31])) begin
      sat32 = x[31:0];
    end else begin
      sat32 = x[AC-1] ? 32'sh80000000 : 32'sh7fffffff;
    end
  endfunction

  logic signed [31:0]    p_r [3];
  logic signed [31:0]    n_r [3];
  logic [31:0]           bones_r;
  logic [63:0]           weights_r;
  logic [8:0]            bone_count;
  logic signed [31:0]    ram_q;
  logic signed [63:0]    prod;
  logic signed [AC-1:0]  accd;
  logic signed [AC-1:0]  acct;
  logic signed [31:0]    rot [3];
  logic signed [31:0]    tp [3];
  logic [63:0]           sq;
  logic signed [31:0]    nu [3];
  logic signed [AC-1:0]  pacc [3];
  logic signed [AC-1:0]  nacc [3];
  logic [WW-1:0]         wtot;
  logic signed [31:0]    pout [3];
  logic signed [31:0]    vsum [3];

  logic [15:0]           cur_w;
  logic [7:0]            cur_b;
  logic [31:0]           waddr_full;
  logic [31:0]           raddr_full;
  logic                  load_we;
  logic                  mul_en;
  logic signed [32:0]    mul_a;
  logic signed [32:0]    mul_b;
  logic signed [65:0]    mul_full;
  logic signed [AC-1:0]  qm;
  logic signed [31:0]    nsrc;
  logic signed [AC-1:0]  div_dividend;
  logic [31:0]           div_divisor;
  logic                  div_start;
  logic                  div_busy;
  logic signed [31:0]    div_q;
  logic                  sqrt_busy;
  logic [31:0]           sqrt_root;
  logic [1:0]            ri;
  logic [1:0]            hi;
  logic                  skinned;
  logic                  out_free;

  assign ri    = cmd.idx[1:0];
  assign hi    = 2'(cmd.idx - 3'd3);
  assign cur_w = weights_r[16*cmd.slot[1:0] +: 16];
  assign cur_b = bones_r[8*cmd.slot[1:0] +: 8];

  // Bone matrix store
  assign load_we    = in_fire && !cmd_in && (32'(load_bone) < MAX_BONES) &&
                      (load_element < 4'(lbvs_pkg::MAT_WORDS));
  assign waddr_full = 32'(load_bone) * 32'd12 + 32'(load_element);
  assign raddr_full = 32'(cur_b) * 32'd12 + 32'({cmd.row, cmd.idx[1:0]});

  lbvs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr_full[AW-1:0]),
    .wdata (load_value),
    .re    (cmd.op == lbvs_pkg::OP_RD),
    .raddr (raddr_full[AW-1:0]),
    .rdata (ram_q)
  );

  // Select operands of the shared multiplier
  assign nsrc = cmd.vsel ? vsum[ri] : rot[ri];

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      lbvs_pkg::OP_MUL_N: begin
        mul_a = 33'(ram_q);
        mul_b = 33'(n_r[ri]);
      end
      lbvs_pkg::OP_MUL_P: begin
        mul_a = 33'(ram_q);
        mul_b = 33'(p_r[ri]);
      end
      lbvs_pkg::OP_SQ_MUL: begin
        mul_a = 33'(nsrc);
        mul_b = 33'(nsrc);
      end
      lbvs_pkg::OP_WMUL_P: begin
        mul_a = 33'(tp[cmd.row]);
        mul_b = $signed({17'b0, cur_w});
      end
      lbvs_pkg::OP_WMUL_N: begin
        mul_a = 33'(nu[cmd.row]);
        mul_b = $signed({17'b0, cur_w});
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign qm       = AC'(prod >>> 16);

  // Divider and square root units
  assign div_start = (cmd.op == lbvs_pkg::OP_DIV_NRM) || (cmd.op == lbvs_pkg::OP_DIV_FIN);

  always_comb begin
    if (cmd.op == lbvs_pkg::OP_DIV_FIN) begin
      div_dividend = (cmd.idx < 3'd3) ? pacc[ri] : nacc[hi];
      div_divisor  = 32'(wtot);
    end else begin
      div_dividend = $signed({{(AC-48){nsrc[31]}}, nsrc, 16'b0});
      div_divisor  = sqrt_root;
    end
  end

  lbvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_q)
  );

  lbvs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == lbvs_pkg::OP_SQRT_GO),
    .radicand (sq),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  // Status back to the controller
  assign skinned  = wtot > WW'(lbvs_pkg::WEIGHT_MIN);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.w_zero    = (cur_w == 16'd0);
    sts.bone_skip = ({1'b0, cur_b} >= bone_count) || (32'(cur_b) >= MAX_BONES);
    sts.sq_big    = cmd.vsel ? (sq != 64'd0) : (sq > 64'(lbvs_pkg::NRM_MIN_SQ));
    sts.skinned   = skinned;
    sts.sqrt_busy = sqrt_busy;
    sts.div_busy  = div_busy;
    sts.out_free  = out_free;
  end

  // Hold the bone count register
  always_ff @(posedge clk) begin
    if (rst) begin
      bone_count <= '0;
    end else if (cfg_we) begin
      bone_count <= cfg_wdata;
    end
  end

  // Hold the product of the shared multiplier
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_full[63:0];
    end
  end

  // Capture the vertex, then run the commanded step
  always_ff @(posedge clk) begin
    if (in_fire && cmd_in) begin
      p_r[0]    <= pos_x;
      p_r[1]    <= pos_y;
      p_r[2]    <= pos_z;
      n_r[0]    <= nrm_x;
      n_r[1]    <= nrm_y;
      n_r[2]    <= nrm_z;
      bones_r   <= influence_bones;
      weights_r <= influence_weights;
      accd      <= '0;
      acct      <= '0;
      wtot      <= '0;
      for (int i = 0; i < 3; i++) begin
        pacc[i] <= '0;
        nacc[i] <= '0;
      end
    end else begin
      case (cmd.op)
        lbvs_pkg::OP_MUL_P:   accd <= accd + qm;
        lbvs_pkg::OP_ACC_P:   acct <= acct + qm;
        lbvs_pkg::OP_ADD_T:   acct <= acct + AC'(ram_q);
        lbvs_pkg::OP_ROW_END: begin
          rot[cmd.row] <= sat32(accd);
          tp[cmd.row]  <= sat32(acct);
          accd         <= '0;
          acct         <= '0;
        end
        lbvs_pkg::OP_SQ_ACC:  sq <= (cmd.idx == 3'd0) ? prod : sq + prod;
        lbvs_pkg::OP_NRM_ST:  nu[ri] <= div_q;
        lbvs_pkg::OP_NRM_FALL: begin
          for (int i = 0; i < 3; i++) begin
            nu[i] <= cmd.vsel ? 32'sd0 : n_r[i];
          end
        end
        lbvs_pkg::OP_WACC_P:  pacc[cmd.row] <= pacc[cmd.row] + prod[AC-1:0];
        lbvs_pkg::OP_WACC_N:  nacc[cmd.row] <= nacc[cmd.row] + prod[AC-1:0];
        lbvs_pkg::OP_WTOT:    wtot <= wtot + WW'(cur_w);
        lbvs_pkg::OP_FIN_ST: begin
          if (cmd.idx < 3'd3) begin
            pout[ri] <= div_q;
          end else begin
            vsum[hi] <= div_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load on publish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == lbvs_pkg::OP_PUBLISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == lbvs_pkg::OP_PUBLISH && out_free) begin
      out_pos_x   <= skinned ? pout[0] : p_r[0];
      out_pos_y   <= skinned ? pout[1] : p_r[1];
      out_pos_z   <= skinned ? pout[2] : p_r[2];
      out_nrm_x   <= skinned ? nu[0] : n_r[0];
      out_nrm_y   <= skinned ? nu[1] : n_r[1];
      out_nrm_z   <= skinned ? nu[2] : n_r[2];
      was_skinned <= skinned;
    end
  end

endmodule
`default_nettype wire
